>>> sv/lz77rd_pkg.sv
// shared types and constants for the lz77 run decoder
`default_nettype none
package lz77rd_pkg;
    localparam int HistAw = 14;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_HEAD     = 4'd1,
        PH_SHORT2   = 4'd2,
        PH_LONG2    = 4'd3,
        PH_LONGLEN  = 4'd4,
        PH_LONGSTEP = 4'd5,
        PH_LEN8     = 4'd6,
        PH_LEN16HI  = 4'd7,
        PH_LEN16LO  = 4'd8,
        PH_LITDATA  = 4'd9,
        PH_FILLVAL  = 4'd10,
        PH_FILLSTEP = 4'd11,
        PH_RUN      = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_BAD   = 2'd3
    } op_t;

    // history write and read request between parser and ring
    typedef struct packed {
        logic              wr_en;
        logic [HistAw-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [HistAw-1:0] rd_addr;
    } hist_req_t;
endpackage
`default_nettype wire

>>> sv/lz77rd_history.sv
// history ring memory, one write and one registered read per cycle
`default_nettype none
module lz77rd_history
    import lz77rd_pkg::*;
(
    input  wire logic      clk,
    input  wire hist_req_t req,
    output logic [7:0]     rd_data
);
    logic [7:0] mem [0:(1<<HistAw)-1];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end
endmodule
`default_nettype wire

>>> sv/lz77_run_decoder_unit.sv
// top level of the lz77 run decoder
// lz77 run decoder: takes one request per cycle (start, compressed byte or tick)
// and returns exactly one result request for each. the 16 KiB history sits in a
// single-port-write synchronous ram; a tick in a copy run reads history in the
// cycle it is accepted; the step byte is added and history written in the
// output stage, the write once its result is taken. back-to-back copies whose
// source is the byte still in the output stage (distance one) are served by
// forwarding from that stage. sustained rate is one item per cycle, limited
// only by the output handshake; the history ram holds undefined data until
// written and needs no clearing pass.
`default_nettype none
module lz77_run_decoder_unit
    import lz77rd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // opcode[1:0], in_byte[9:2], zero pad
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic [15:0] m_tdata, // out_byte, out_valid, need_byte, finished,
                                 // size_ok, protocol_error, zero pad
    input  wire logic        cfg_we,
    input  wire logic [23:0] cfg_wdata
);
    phase_t            phase_reg, phase_next;
    logic [HistAw-1:0] wpos_reg, wpos_next;
    logic signed [24:0] remain_reg, remain_next;
    logic [7:0]  head_reg, head_next;
    logic [14:0] dist_reg, dist_next;
    logic [16:0] left_reg, left_next;
    logic [7:0]  fill_reg, fill_next;
    logic [7:0]  step_reg, step_next;
    logic        ramp_reg, ramp_next;
    logic [23:0] size_reg;

    // output stage
    logic        ov_reg;          // stage holds a result
    logic        oemit_reg;       // result carries a byte
    logic        ocopy_reg;       // byte comes from history read
    logic [7:0]  obyte_reg;       // literal/fill byte or copy step
    logic [HistAw-1:0] oaddr_reg; // history write address
    logic        ofwd_reg;        // copy source is the previous emitted byte
    logic [7:0]  prev_reg;        // last emitted byte value
    logic        oneed_reg, ofin_reg, ook_reg, oerr_reg;

    logic [7:0]  hist_q;
    hist_req_t   hreq;
    logic        take;
    op_t         op;
    logic [7:0]  b;
    logic        emit, copy_rd, err;
    logic [7:0]  ebyte;
    logic [7:0]  out_val;

    assign op   = op_t'(s_tdata[1:0]);
    assign b    = s_tdata[9:2];
    assign s_tready = !ov_reg || m_tready;
    assign take = s_tvalid && s_tready;

    // byte leaving the output stage: forwarded, read, or direct
    always_comb
    begin
        if (ocopy_reg)
        begin
            out_val = (ofwd_reg ? prev_reg : hist_q) + obyte_reg;
        end
        else
        begin
            out_val = obyte_reg;
        end
    end

    always_comb
    begin
        logic [HistAw-1:0] src;
        logic [5:0] kind;
        logic       finish;
        phase_next  = phase_reg;
        wpos_next   = wpos_reg;
        remain_next = remain_reg;
        head_next   = head_reg;
        dist_next   = dist_reg;
        left_next   = left_reg;
        fill_next   = fill_reg;
        step_next   = step_reg;
        ramp_next   = ramp_reg;
        emit = 1'b0;
        copy_rd = 1'b0;
        err  = 1'b0;
        ebyte = b;
        finish = 1'b0;
        kind = head_reg[5:0];
        src = wpos_reg - dist_reg[HistAw-1:0];
        unique case (op)
            OP_START:
            begin
                remain_next = {1'b0, size_reg};
                left_next   = '0;
                phase_next  = (size_reg == '0) ? PH_IDLE : PH_HEAD;
            end
            OP_BYTE:
            begin
                if (phase_reg == PH_IDLE || phase_reg == PH_RUN)
                begin
                    err = 1'b1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_HEAD:
                        begin
                            head_next = b;
                            if (b[7] && b[6])
                                phase_next = PH_LONG2;
                            else if (b[7])
                            begin
                                step_next = '0;
                                if (b[5:0] == 6'd1) phase_next = PH_LEN8;
                                else if (b[5:0] == 6'd2) phase_next = PH_LEN16HI;
                                else if (b[5:0] >= 6'd3 && b[5:0] <= 6'd6)
                                    phase_next = PH_FILLVAL;
                                else
                                    phase_next = (remain_reg <= 0) ? PH_IDLE : PH_HEAD;
                            end
                            else
                                phase_next = PH_SHORT2;
                        end
                        PH_SHORT2:
                        begin
                            left_next = (b[3:0] == '0) ? 17'h10 : {13'd0, b[3:0]};
                            dist_next = ({head_reg[6:0], b[7:4]} == '0) ? 15'h800
                                      : {4'd0, head_reg[6:0], b[7:4]};
                            step_next = '0;
                            ramp_next = 1'b0;
                            phase_next = PH_RUN;
                        end
                        PH_LONG2:
                        begin
                            dist_next = ({head_reg[5:0], b} == '0) ? 15'h4000
                                      : {1'b0, head_reg[5:0], b};
                            phase_next = PH_LONGLEN;
                        end
                        PH_LONGLEN:
                        begin
                            left_next = (b[6:0] == '0) ? 17'h80 : {10'd0, b[6:0]};
                            step_next = '0;
                            ramp_next = 1'b0;
                            phase_next = b[7] ? PH_LONGSTEP : PH_RUN;
                        end
                        PH_LONGSTEP:
                        begin
                            step_next = b;
                            phase_next = PH_RUN;
                        end
                        PH_FILLVAL:
                        begin
                            fill_next = b;
                            if (kind >= 6'd5) phase_next = PH_FILLSTEP;
                            else phase_next = (kind == 6'd3) ? PH_LEN8 : PH_LEN16HI;
                        end
                        PH_FILLSTEP:
                        begin
                            step_next = b;
                            phase_next = (kind == 6'd5) ? PH_LEN8 : PH_LEN16HI;
                        end
                        PH_LEN8:
                        begin
                            left_next = (b == '0) ? 17'h100 : {9'd0, b};
                            if (kind == 6'd1 || kind == 6'd2) phase_next = PH_LITDATA;
                            else
                            begin
                                ramp_next = 1'b1;
                                phase_next = PH_RUN;
                            end
                        end
                        PH_LEN16HI:
                        begin
                            left_next = {1'b0, b, 8'd0};
                            phase_next = PH_LEN16LO;
                        end
                        PH_LEN16LO:
                        begin
                            left_next = ({left_reg[15:8], b} == '0) ? 17'h10000
                                      : {1'b0, left_reg[15:8], b};
                            if (kind == 6'd1 || kind == 6'd2) phase_next = PH_LITDATA;
                            else
                            begin
                                ramp_next = 1'b1;
                                phase_next = PH_RUN;
                            end
                        end
                        PH_LITDATA:
                        begin
                            emit = 1'b1;
                            ebyte = b;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            OP_TICK:
            begin
                if (phase_reg != PH_RUN)
                begin
                    err = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                    if (ramp_reg)
                    begin
                        ebyte = fill_reg;
                        fill_next = fill_reg + step_reg;
                    end
                    else
                    begin
                        copy_rd = 1'b1;
                        ebyte = step_reg;
                    end
                end
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
        if (emit)
        begin
            wpos_next   = wpos_reg + HistAw'(1);
            remain_next = remain_reg - 25'sd1;
            left_next   = left_reg - 17'd1;
            finish      = (left_reg == 17'd1);
            if (finish)
                phase_next = (remain_next <= 0) ? PH_IDLE : PH_HEAD;
        end
        hreq.rd_en   = take && copy_rd;
        hreq.rd_addr = src;
        hreq.wr_en   = ov_reg && oemit_reg && m_tready;
        hreq.wr_addr = oaddr_reg;
        hreq.wr_data = out_val;
    end

    lz77rd_history u_hist (
        .clk     (clk),
        .req     (hreq),
        .rd_data (hist_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            wpos_reg   <= '0;
            remain_reg <= '0;
            head_reg   <= '0;
            dist_reg   <= '0;
            left_reg   <= '0;
            fill_reg   <= '0;
            step_reg   <= '0;
            ramp_reg   <= 1'b0;
            size_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (ov_reg && m_tready)
            begin
                ov_reg <= 1'b0;
            end
            if (take)
            begin
                phase_reg  <= phase_next;
                wpos_reg   <= wpos_next;
                remain_reg <= remain_next;
                head_reg   <= head_next;
                dist_reg   <= dist_next;
                left_reg   <= left_next;
                fill_reg   <= fill_next;
                step_reg   <= step_next;
                ramp_reg   <= ramp_next;
                ov_reg     <= 1'b1;
            end
        end
    end

    // payload of the output stage
    always_ff @(posedge clk)
    begin
        if (ov_reg && m_tready && oemit_reg)
        begin
            prev_reg <= out_val;
        end
        if (take)
        begin
            oemit_reg <= emit;
            ocopy_reg <= copy_rd;
            obyte_reg <= ebyte;
            oaddr_reg <= wpos_reg;
            // source equals the byte still pending in the output stage
            ofwd_reg  <= copy_rd && dist_reg == 15'd1 && ov_reg && oemit_reg;
            oneed_reg <= phase_next != PH_IDLE && phase_next != PH_RUN;
            ofin_reg  <= phase_next == PH_IDLE;
            ook_reg   <= phase_next == PH_IDLE && remain_next == 0;
            oerr_reg  <= err;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {3'd0, oerr_reg, ook_reg, ofin_reg, oneed_reg, oemit_reg,
                       oemit_reg ? out_val : 8'd0};

    // a byte is never emitted from the idle phase
    assert property (@(posedge clk) disable iff (!rst_n)
        take && phase_reg == PH_IDLE |-> !emit)
        else $error("emit while idle");
    // a held result does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !m_tready |=> ov_reg && $stable(oemit_reg) && $stable(oerr_reg))
        else $error("output stage changed while stalled");
    // forwarding only for copies
    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ofwd_reg |-> ocopy_reg)
        else $error("forward without copy");
endmodule
`default_nettype wire
